/* design/dpu_pkg.sv */
// Shared types and constants for the depth pixel unprojection block.
// Holds the configuration register layout, register indexes and reset values.
// No dependencies; every other design file imports this package.
package dpu_pkg;

  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned Z_W        = 15;
  localparam int unsigned CENTER_W   = 14;
  localparam int unsigned RECIP_W    = 32;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned POS_OUT_W  = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OUT_TDATA_W = 104;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_MAX_DEPTH    = 3'd2,
    CFG_CENTER_X     = 3'd3,
    CFG_CENTER_Y     = 3'd4,
    CFG_RECIP_FX     = 3'd5,
    CFG_RECIP_FY     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [SIZE_W-1:0]   frame_width;
    logic [SIZE_W-1:0]   frame_height;
    logic [Z_W-1:0]      max_depth;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [RECIP_W-1:0]  recip_fx;
    logic [RECIP_W-1:0]  recip_fy;
  } cfg_t;

  localparam logic [SIZE_W-1:0]   RST_FRAME_WIDTH  = 11'd640;
  localparam logic [SIZE_W-1:0]   RST_FRAME_HEIGHT = 11'd480;
  localparam logic [Z_W-1:0]      RST_MAX_DEPTH    = 15'd10000;
  localparam logic [CENTER_W-1:0] RST_CENTER_X     = 14'd5120;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 14'd3840;
  localparam logic [RECIP_W-1:0]  RST_RECIP_F      = 32'd7469508;

endpackage

/* design/dpu_fifo.sv */
// Small queue between the front (position tracking) and the back (projection).
// Registers only; entry width is set by the instantiating module.
// Depends on dpu_pkg for the queue depth.
module dpu_fifo #(
  parameter int unsigned WIDTH = 37
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import dpu_pkg::*;

  localparam int unsigned DEPTH = QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [AW:0]      count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (AW+1)'(DEPTH)) else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from an empty queue");
`endif

endmodule

/* design/dpu_front.sv */
// Front end: accepts depth beats, tracks column and row, classifies the depth
// against max_depth and pushes one entry per beat into the queue.
// Depends on dpu_pkg for the configuration struct.
module dpu_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned EW         = 37
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dpu_pkg::cfg_t              cfg_i,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [dpu_pkg::DEPTH_W-1:0] s_depth_i,
  input  logic                       full_i,
  output logic                       push_o,
  output logic [EW-1:0]              entry_o
);
  import dpu_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW:0]   w_eff;
  logic [RW:0]   h_eff;
  logic          last_col, last_row, frame_end, in_range;
  logic [Z_W-1:0] mag;

  // Clamp the programmed frame size into 1..MAX.
  always_comb begin
    if (cfg_i.frame_width == '0) begin
      w_eff = (CW+1)'(1);
    end else if (cfg_i.frame_width > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height == '0) begin
      h_eff = (RW+1)'(1);
    end else if (cfg_i.frame_height > MAX_HEIGHT) begin
      h_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(cfg_i.frame_height);
    end
  end

  assign last_col  = ({1'b0, col_q} + 1'b1) >= w_eff;
  assign last_row  = ({1'b0, row_q} + 1'b1) >= h_eff;
  assign frame_end = last_col && last_row;
  assign mag       = s_depth_i[Z_W-1:0];
  assign in_range  = !s_depth_i[DEPTH_W-1] && (mag != '0) && (mag < cfg_i.max_depth);

  assign s_ready_o = !full_i;
  assign push_o    = s_valid_i && !full_i;
  assign entry_o   = EW'({frame_end, in_range, mag, row_q, col_q});

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

`ifndef SYNTHESIS
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW+1)'(col_q) < (CW+1)'(MAX_WIDTH)) else $error("column counter out of range");
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (RW+1)'(row_q) < (RW+1)'(MAX_HEIGHT)) else $error("row counter out of range");
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_o |=> ($stable(col_q) && $stable(row_q)))
    else $error("position moved without a beat");
`endif

endmodule

/* design/dpu_proj.sv */
// One projection lane: coord = round(d * |pos*16 - ctr| * recip / 2^32) with sign
// and 32-bit saturation, in four registered steps that advance on en_i.
// Depends on dpu_pkg for field widths.
module dpu_proj #(
  parameter int unsigned POS_W = 10
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          keep_i,
  input  logic [POS_W-1:0]              pos_i,
  input  logic [dpu_pkg::CENTER_W-1:0]  ctr_i,
  input  logic [dpu_pkg::Z_W-1:0]       depth_i,
  input  logic [dpu_pkg::RECIP_W-1:0]   recip_i,
  output logic [dpu_pkg::COORD_W-1:0]   coord_o
);
  import dpu_pkg::*;

  localparam int unsigned OW = ((POS_W + 4 > CENTER_W) ? POS_W + 4 : CENTER_W) + 1;
  localparam int unsigned MW = OW - 1;
  localparam int unsigned PW = Z_W + MW;
  localparam int unsigned FW = PW + RECIP_W;

  logic [OW-1:0]    off, off_abs;
  logic [MW-1:0]    mag_q;
  logic [Z_W-1:0]   d_q;
  logic             neg1_q, neg2_q, neg3_q;
  logic [PW-1:0]    prod_d, prod_q;
  logic [FW-1:0]    full_d, full_q;
  logic [63:0]      q64;
  logic [COORD_W-1:0] coord_d;

  // Offset from the principal point in Q.4 pixels; out-of-range pixels get zero.
  assign off     = OW'({pos_i, 4'b0000}) - OW'(ctr_i);
  assign off_abs = off[OW-1] ? (~off + 1'b1) : off;
  assign prod_d  = PW'(d_q) * PW'(mag_q);
  assign full_d  = FW'(prod_q) * FW'(recip_i);
  assign q64     = 64'(full_q >> RECIP_W) + 64'(full_q[RECIP_W-1]);

  always_comb begin
    if (neg3_q) begin
      coord_d = (q64 > 64'h8000_0000) ? 32'h8000_0000 : COORD_W'(64'd0 - q64);
    end else begin
      coord_d = (q64 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q64[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= keep_i ? off_abs[MW-1:0] : '0;
      neg1_q  <= keep_i && off[OW-1];
      d_q     <= depth_i;
      prod_q  <= prod_d;
      neg2_q  <= neg1_q;
      full_q  <= full_d;
      neg3_q  <= neg2_q;
      coord_o <= coord_d;
    end
  end

endmodule

/* design/dpu_back.sv */
// Back end: pops queue entries and runs the X and Y projection lanes, carrying
// position, depth and flags alongside; the last stage is the output register.
// Depends on dpu_pkg and dpu_proj.
module dpu_back #(
  parameter int unsigned CW = 10,
  parameter int unsigned RW = 10,
  parameter int unsigned EW = 37
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dpu_pkg::cfg_t                   cfg_i,
  input  logic                            q_valid_i,
  input  logic [EW-1:0]                   q_entry_i,
  output logic                            q_pop_o,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output logic [dpu_pkg::POS_OUT_W-1:0]   m_column_o,
  output logic [dpu_pkg::POS_OUT_W-1:0]   m_row_o,
  output logic [dpu_pkg::COORD_W-1:0]     m_point_x_o,
  output logic [dpu_pkg::COORD_W-1:0]     m_point_y_o,
  output logic [dpu_pkg::Z_W-1:0]         m_point_z_o,
  output logic                            m_in_range_o,
  output logic                            m_frame_end_o
);
  import dpu_pkg::*;

  localparam int unsigned NST = 4;

  logic [CW-1:0]  e_col;
  logic [RW-1:0]  e_row;
  logic [Z_W-1:0] e_depth, e_z;
  logic           e_rng, e_fe, adv;

  logic [NST-1:0]       vld_q;
  logic [POS_OUT_W-1:0] col_q [NST];
  logic [POS_OUT_W-1:0] row_q [NST];
  logic [Z_W-1:0]       z_q   [NST];
  logic [NST-1:0]       rng_q, fe_q;

  assign e_col   = q_entry_i[CW-1:0];
  assign e_row   = q_entry_i[CW+RW-1:CW];
  assign e_depth = q_entry_i[CW+RW+Z_W-1:CW+RW];
  assign e_rng   = q_entry_i[CW+RW+Z_W];
  assign e_fe    = q_entry_i[CW+RW+Z_W+1];
  assign e_z     = e_rng ? e_depth : '0;

  // The whole pipeline moves together whenever the output register can drain.
  assign adv     = !vld_q[NST-1] || m_ready_i;
  assign q_pop_o = adv && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], q_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      col_q[0] <= POS_OUT_W'(e_col);
      row_q[0] <= POS_OUT_W'(e_row);
      z_q[0]   <= e_z;
      rng_q    <= {rng_q[NST-2:0], e_rng};
      fe_q     <= {fe_q[NST-2:0], e_fe};
      for (int k = 1; k < NST; k++) begin
        col_q[k] <= col_q[k-1];
        row_q[k] <= row_q[k-1];
        z_q[k]   <= z_q[k-1];
      end
    end
  end

  dpu_proj #(.POS_W(CW)) u_proj_x (
    .clk_i   (clk_i),
    .en_i    (adv),
    .keep_i  (e_rng),
    .pos_i   (e_col),
    .ctr_i   (cfg_i.center_x),
    .depth_i (e_depth),
    .recip_i (cfg_i.recip_fx),
    .coord_o (m_point_x_o)
  );

  dpu_proj #(.POS_W(RW)) u_proj_y (
    .clk_i   (clk_i),
    .en_i    (adv),
    .keep_i  (e_rng),
    .pos_i   (e_row),
    .ctr_i   (cfg_i.center_y),
    .depth_i (e_depth),
    .recip_i (cfg_i.recip_fy),
    .coord_o (m_point_y_o)
  );

  assign m_valid_o     = vld_q[NST-1];
  assign m_column_o    = col_q[NST-1];
  assign m_row_o       = row_q[NST-1];
  assign m_point_z_o   = z_q[NST-1];
  assign m_in_range_o  = rng_q[NST-1];
  assign m_frame_end_o = fe_q[NST-1];

`ifndef SYNTHESIS
  a_zero_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && !m_in_range_o) |-> (m_point_x_o == '0 && m_point_y_o == '0 &&
    m_point_z_o == '0)) else $error("out-of-range point is not zero");
  a_depth_when_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && m_in_range_o) |-> (m_point_z_o != '0))
    else $error("in-range point has zero depth");
  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> vld_q[0]) else $error("popped entry lost at first stage");
`endif

endmodule

/* design/depth_pixel_unprojection.sv */
// Depth pixel unprojection: a stream of depth samples in, one 3-D point out per sample.
// Usage:
//   s_axis carries one signed 16-bit depth sample (mm) per beat, row-major order.
//   m_axis returns one beat per input beat, in order: column, row, X and Y in
//   1/16 mm (saturated to 32 bits) and Z in mm in tdata, the in-range flag in
//   tuser, and tlast on the last pixel of the frame.
//   The cfg channel writes one register per beat (index 0..6: frame_width,
//   frame_height, max_depth, center_x, center_y, recip_fx, recip_fy); it is
//   always ready and should only be used while the block is idle.
// Timing: an accepted sample passes the input queue and the four projection
//   stages to m_axis; one beat per cycle is sustained while m_axis_tready is
//   high. The queue holds four entries; each coordinate uses two multipliers.
// Stall: while m_axis_tvalid is high and m_axis_tready low the projection pipeline
//   holds; input is still taken until the queue fills, then s_axis_tready drops.
// Reset: registers return to their default values, column and row restart at
//   zero and the queue and pipeline are emptied.
// Depends on dpu_pkg, dpu_front, dpu_fifo, dpu_proj and dpu_back.
module depth_pixel_unprojection #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dpu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dpu_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // tdata: depth_mm[15:0].
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dpu_pkg::DEPTH_W-1:0]       s_axis_tdata,
  // tdata: column[9:0], row[19:10], point_x[51:20], point_y[83:52],
  // point_z[98:84], zero fill[103:99].
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dpu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // tuser: in_range[0].
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);
  import dpu_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned EW = CW + RW + Z_W + 2;
  localparam int unsigned PAD_W = OUT_TDATA_W - 2*POS_OUT_W - 2*COORD_W - Z_W;

  cfg_t cfg_q;

  logic                 push, full, q_valid, q_pop;
  logic [EW-1:0]        push_entry, q_entry;
  logic [POS_OUT_W-1:0] col_out, row_out;
  logic [COORD_W-1:0]   x_out, y_out;
  logic [Z_W-1:0]       z_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= RST_FRAME_WIDTH;
      cfg_q.frame_height <= RST_FRAME_HEIGHT;
      cfg_q.max_depth    <= RST_MAX_DEPTH;
      cfg_q.center_x     <= RST_CENTER_X;
      cfg_q.center_y     <= RST_CENTER_Y;
      cfg_q.recip_fx     <= RST_RECIP_F;
      cfg_q.recip_fy     <= RST_RECIP_F;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[SIZE_W-1:0];
        CFG_MAX_DEPTH:    cfg_q.max_depth    <= cfg_data_i[Z_W-1:0];
        CFG_CENTER_X:     cfg_q.center_x     <= cfg_data_i[CENTER_W-1:0];
        CFG_CENTER_Y:     cfg_q.center_y     <= cfg_data_i[CENTER_W-1:0];
        CFG_RECIP_FX:     cfg_q.recip_fx     <= cfg_data_i[RECIP_W-1:0];
        CFG_RECIP_FY:     cfg_q.recip_fy     <= cfg_data_i[RECIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dpu_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .EW         (EW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_depth_i (s_axis_tdata),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  dpu_fifo #(.WIDTH(EW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_entry)
  );

  dpu_back #(.CW(CW), .RW(RW), .EW(EW)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_column_o    (col_out),
    .m_row_o       (row_out),
    .m_point_x_o   (x_out),
    .m_point_y_o   (y_out),
    .m_point_z_o   (z_out),
    .m_in_range_o  (m_axis_tuser),
    .m_frame_end_o (m_axis_tlast)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, z_out, y_out, x_out, row_out, col_out};

endmodule
